// ===== design/hrp_pkg.sv =====
// Shared types and constants for the hex record parser.
// Used by the front classifier, the token queue, the back parser and the top level.
package hrp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;

  // Token queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Record-end status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_FMT  = 2'd2;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Character class found by the front
  typedef enum logic [1:0] {
    TK_NEWLINE,
    TK_COLON,
    TK_HEX,
    TK_OTHER
  } tok_class_t;

  // Classified character word
  typedef struct packed {
    tok_class_t  cls;
    logic [3:0]  nib;
  } hrp_token_t;

  // Line parsing phases
  typedef enum logic [2:0] {
    PH_START,
    PH_LEN,
    PH_ADRH,
    PH_ADRL,
    PH_TYPE,
    PH_DATA,
    PH_CSUM,
    PH_SKIP
  } phase_t;

  // One result word
  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  count;
    logic [7:0]  rtype;
    logic [15:0] addr;
    logic [7:0]  data;
  } hrp_result_t;

endpackage

// ===== design/hrp_front.sv =====
// Front stage: registers each accepted character and classifies it.
// Depends on hrp_pkg for the token type and character codes.
module hrp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  output logic              tok_valid,
  input  logic              tok_ready,
  output hrp_pkg::hrp_token_t tok
);

  logic                tok_valid_r, tok_valid_nxt;
  hrp_pkg::hrp_token_t tok_r, tok_nxt;

  // Accept a new word whenever the stage is empty or drains this cycle
  assign in_ready  = !tok_valid_r || tok_ready;
  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;

  // Classify the incoming character
  always_comb begin
    tok_nxt = tok_r;
    if (in_char == hrp_pkg::CHAR_NEWLINE) begin
      tok_nxt.cls = hrp_pkg::TK_NEWLINE;
      tok_nxt.nib = 4'd0;
    end else if (in_char == hrp_pkg::CHAR_COLON) begin
      tok_nxt.cls = hrp_pkg::TK_COLON;
      tok_nxt.nib = 4'd0;
    end else if (in_char inside {[8'h30:8'h39]}) begin
      tok_nxt.cls = hrp_pkg::TK_HEX;
      tok_nxt.nib = 4'(in_char - 8'h30);
    end else if (in_char inside {[8'h41:8'h46]}) begin
      tok_nxt.cls = hrp_pkg::TK_HEX;
      tok_nxt.nib = 4'(in_char - 8'h37);
    end else if (in_char inside {[8'h61:8'h66]}) begin
      tok_nxt.cls = hrp_pkg::TK_HEX;
      tok_nxt.nib = 4'(in_char - 8'h57);
    end else begin
      tok_nxt.cls = hrp_pkg::TK_OTHER;
      tok_nxt.nib = 4'd0;
    end
  end

  // Hold or advance the stage valid
  always_comb begin
    tok_valid_nxt = tok_valid_r;
    if (in_ready) begin
      tok_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

// ===== design/hrp_queue.sv =====
// Short token queue that decouples the front classifier from the back parser.
// Depends on hrp_pkg for the token type and queue depth.
module hrp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  hrp_pkg::hrp_token_t push_tok,
  output logic                pop_valid,
  input  logic                pop_ready,
  output hrp_pkg::hrp_token_t pop_tok
);

  hrp_pkg::hrp_token_t                 mem_r [hrp_pkg::QDEPTH];
  logic [hrp_pkg::QPTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [hrp_pkg::QPTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [hrp_pkg::QCNT_W-1:0]          count_r, count_nxt;
  logic                                push, pop;

  assign push_ready = (count_r != hrp_pkg::QCNT_W'(hrp_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == hrp_pkg::QPTR_W'(hrp_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == hrp_pkg::QPTR_W'(hrp_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hrp_pkg::QCNT_W'(hrp_pkg::QDEPTH))
    else $error("queue fill count beyond depth");

  a_pop_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on pop");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers differ while empty");

endmodule

// ===== design/hrp_back.sv =====
// Back parser: walks the record fields per token and drives the result register.
// Depends on hrp_pkg for token, phase and result types and status codes.
module hrp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  hrp_pkg::hrp_token_t tok,
  output logic                res_valid,
  input  logic                res_ready,
  output hrp_pkg::hrp_result_t res
);

  hrp_pkg::phase_t      phase_r, phase_nxt;
  logic [3:0]           high_r, high_nxt;
  logic                 second_r, second_nxt;
  logic [7:0]           len_r, len_nxt;
  logic [15:0]          base_r, base_nxt;
  logic [7:0]           type_r, type_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [7:0]           idx_r, idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  hrp_pkg::hrp_result_t out_res_r;
  logic                 emit;
  hrp_pkg::hrp_result_t emit_res;

  logic                 take;
  logic [7:0]           value;
  logic [7:0]           sum_add;
  logic [7:0]           idx_inc;

  // Take a token when the result register is free or drains this cycle
  assign tok_ready = !out_valid_r || res_ready;
  assign take      = tok_valid && tok_ready;
  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  assign value   = {high_r, tok.nib};
  assign sum_add = sum_r + value;
  assign idx_inc = idx_r + 8'd1;

  // Next state of the line parser
  always_comb begin
    phase_nxt  = phase_r;
    high_nxt   = high_r;
    second_nxt = second_r;
    len_nxt    = len_r;
    base_nxt   = base_r;
    type_nxt   = type_r;
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    case (phase_r)
      hrp_pkg::PH_START: begin
        if (tok.cls != hrp_pkg::TK_NEWLINE) begin
          len_nxt    = '0;
          base_nxt   = '0;
          type_nxt   = '0;
          sum_nxt    = '0;
          idx_nxt    = '0;
          high_nxt   = '0;
          second_nxt = 1'b0;
          phase_nxt  = (tok.cls == hrp_pkg::TK_COLON) ? hrp_pkg::PH_LEN
                                                      : hrp_pkg::PH_SKIP;
        end
      end
      hrp_pkg::PH_SKIP: begin
        if (tok.cls == hrp_pkg::TK_NEWLINE) begin
          phase_nxt = hrp_pkg::PH_START;
        end
      end
      default: begin
        if (tok.cls == hrp_pkg::TK_NEWLINE) begin
          phase_nxt = hrp_pkg::PH_START;
        end else if (tok.cls != hrp_pkg::TK_HEX) begin
          phase_nxt = hrp_pkg::PH_SKIP;
        end else if (!second_r) begin
          high_nxt   = tok.nib;
          second_nxt = 1'b1;
        end else begin
          second_nxt = 1'b0;
          sum_nxt    = sum_add;
          case (phase_r)
            hrp_pkg::PH_LEN: begin
              len_nxt   = value;
              phase_nxt = hrp_pkg::PH_ADRH;
            end
            hrp_pkg::PH_ADRH: begin
              base_nxt  = {value, 8'd0};
              phase_nxt = hrp_pkg::PH_ADRL;
            end
            hrp_pkg::PH_ADRL: begin
              base_nxt  = {base_r[15:8], value};
              phase_nxt = hrp_pkg::PH_TYPE;
            end
            hrp_pkg::PH_TYPE: begin
              type_nxt  = value;
              phase_nxt = (len_r == 8'd0) ? hrp_pkg::PH_CSUM : hrp_pkg::PH_DATA;
            end
            hrp_pkg::PH_DATA: begin
              idx_nxt = idx_inc;
              if (idx_inc == len_r) begin
                phase_nxt = hrp_pkg::PH_CSUM;
              end
            end
            default: begin
              phase_nxt = hrp_pkg::PH_SKIP;
            end
          endcase
        end
      end
    endcase
  end

  // Result produced by the current token
  always_comb begin
    emit           = 1'b0;
    emit_res.kind  = hrp_pkg::KIND_END;
    emit_res.status = hrp_pkg::ST_OK;
    emit_res.count = idx_nxt;
    emit_res.rtype = type_nxt;
    emit_res.addr  = base_nxt;
    emit_res.data  = 8'd0;
    case (phase_r)
      hrp_pkg::PH_START: begin
        if (tok.cls != hrp_pkg::TK_NEWLINE && tok.cls != hrp_pkg::TK_COLON) begin
          emit            = 1'b1;
          emit_res.status = hrp_pkg::ST_FMT;
        end
      end
      hrp_pkg::PH_SKIP: begin
        emit = 1'b0;
      end
      default: begin
        if (tok.cls != hrp_pkg::TK_HEX) begin
          emit            = 1'b1;
          emit_res.status = hrp_pkg::ST_FMT;
        end else if (second_r) begin
          if (phase_r == hrp_pkg::PH_DATA) begin
            emit           = 1'b1;
            emit_res.kind  = hrp_pkg::KIND_DATA;
            emit_res.data  = value;
            emit_res.addr  = base_r + {8'd0, idx_r};
          end else if (phase_r == hrp_pkg::PH_CSUM) begin
            emit            = 1'b1;
            emit_res.status = (sum_add == 8'd0) ? hrp_pkg::ST_OK : hrp_pkg::ST_CSUM;
          end
        end
      end
    endcase
  end

  // Load or drain the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tok_ready) begin
      out_valid_nxt = take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hrp_pkg::PH_START;
      high_r      <= '0;
      second_r    <= 1'b0;
      len_r       <= '0;
      base_r      <= '0;
      type_r      <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r  <= phase_nxt;
        high_r   <= high_nxt;
        second_r <= second_nxt;
        len_r    <= len_nxt;
        base_r   <= base_nxt;
        type_r   <= type_nxt;
        sum_r    <= sum_nxt;
        idx_r    <= idx_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_res_r <= emit_res;
    end
  end

  a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hrp_pkg::PH_DATA) |-> (idx_r < len_r))
    else $error("byte index reached length inside data field");

  a_data_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == hrp_pkg::KIND_DATA) |->
      (out_res_r.count != 8'd0 && out_res_r.status == hrp_pkg::ST_OK))
    else $error("data word with zero count or nonzero status");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("pending result lost while stalled");

endmodule

// ===== design/hex_record_parser_core.sv =====
// Top level of the hex record parser: front classifier, token queue, back parser.
// Depends on hrp_pkg, hrp_front, hrp_queue and hrp_back.
// A character's result passes through the front register, a queue entry and
// the result register, in that order, before it appears at the output.
// Throughput: one character per cycle unless out_tready stalls the back parser.
// Reset (rst_n low, synchronous) empties all stages and returns the parser to line start.
module hex_record_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] data_byte, [23:8] byte_address,
                                  // [31:24] record_type, [39:32] byte_count,
                                  // [41:40] status, [47:42] zero
  output logic        out_tuser   // [0] result_kind
);

  logic                 fq_valid, fq_ready;
  hrp_pkg::hrp_token_t  fq_tok;
  logic                 qb_valid, qb_ready;
  hrp_pkg::hrp_token_t  qb_tok;
  hrp_pkg::hrp_result_t res;

  hrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .tok_valid (fq_valid),
    .tok_ready (fq_ready),
    .tok       (fq_tok)
  );

  hrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_tok   (fq_tok),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_tok    (qb_tok)
  );

  hrp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (qb_valid),
    .tok_ready (qb_ready),
    .tok       (qb_tok),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result word
  assign out_tdata = {6'd0, res.status, res.count, res.rtype, res.addr, res.data};
  assign out_tuser = res.kind;

endmodule
